// ===== rtl/mfp_pkg.sv =====
// Shared types and constants of the measurement frame parser.
// No dependencies; used by mfp_front, mfp_queue, mfp_back and the top level.
package mfp_pkg;

	localparam int MaxDataChars = 255;
	localparam int MaxTokens    = 16;
	localparam int QueueDepth   = 4;

	// Wide enough for the sum of up to 30 saturated tokens
	localparam int SumW = 40;

	localparam int         ChecksumMod   = 255;
	localparam logic [7:0] StatusMaxCode = 8'd6;
	localparam logic [7:0] StatusAltCode = 8'd99;
	localparam int         TempOffset    = 100;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_HEADER   = 2'd1,
		ERR_CHECKSUM = 2'd2,
		ERR_STATUS   = 2'd3
	} err_t;

	// One parsed frame, handed from the parser to the checker
	typedef struct packed {
		logic                   hdr_ok;
		logic                   temp_ok;
		logic signed [SumW-1:0] sum;
		logic signed [31:0]     ck;
		logic signed [31:0]     volt;
		logic signed [31:0]     curr;
		logic signed [31:0]     cap;
		logic signed [31:0]     temp_raw;
		logic        [7:0]      stat;
		logic signed [31:0]     clk_time;
	} rec_t;

endpackage

// ===== rtl/mfp_front.sv =====
// Character parser: header match, tokenizer, decimal accumulation, field capture.
// Depends on mfp_pkg; emits one mfp_pkg::rec_t per frame.
module mfp_front #(
	parameter int MAX_DATA_CHARS = mfp_pkg::MaxDataChars,
	parameter int MAX_TOKENS     = mfp_pkg::MaxTokens
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_in,
	input  logic           frame_last,
	output logic           rec_push,
	output mfp_pkg::rec_t  rec
);

	localparam int DCW  = $clog2(MAX_DATA_CHARS + 1);
	localparam int IDXW = $clog2(MAX_TOKENS + 1);

	localparam logic [7:0]  ChEq     = 8'h3D;
	localparam logic [7:0]  ChComma  = 8'h2C;
	localparam logic [7:0]  ChPlus   = 8'h2B;
	localparam logic [7:0]  ChMinus  = 8'h2D;
	localparam logic [7:0]  ChSpace  = 8'h20;
	localparam logic [7:0]  ChTab    = 8'h09;
	localparam logic [7:0]  ChCr     = 8'h0D;
	localparam logic [7:0]  ChZero   = 8'h30;
	localparam logic [7:0]  ChNine   = 8'h39;
	localparam logic [15:0] HdrTag   = 16'h3530;
	localparam logic [34:0] ValMax   = 35'h0_7FFF_FFFF;

	localparam logic [4:0] TokCk     = 5'd1;
	localparam logic [4:0] TokVolt   = 5'd2;
	localparam logic [4:0] TokCurr   = 5'd3;
	localparam logic [4:0] TokCap    = 5'd4;
	localparam logic [4:0] TokTemp   = 5'd8;
	localparam logic [4:0] TokStatus = 5'd10;
	localparam logic [4:0] TokTime   = 5'd15;
	localparam logic [4:0] TokSumLo  = 5'd2;

	typedef enum logic [1:0] {
		PH_EMPTY = 2'd0,
		PH_SPACE = 2'd1,
		PH_NUM   = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	logic [15:0]                    tail_q;
	logic                           in_data_q;
	logic                           hdr_q;
	logic [DCW-1:0]                 dcount_q;
	logic [IDXW-1:0]                idx_q;
	phase_t                         phase_q;
	logic                           neg_q;
	logic [30:0]                    val_q;
	logic signed [mfp_pkg::SumW-1:0] sum_q;
	logic signed [31:0]             ck_q, volt_q, curr_q, cap_q, temp_q, stat_q, time_q;

	logic [15:0]                    tail_n;
	logic                           in_data_n, hdr_n;
	logic [DCW-1:0]                 dcount_n;
	logic                           take_data, is_digit, is_space, comma, end_now, commit;
	phase_t                         ph_n;
	logic                           neg_n;
	logic [30:0]                    val_n;
	logic [34:0]                    mac;
	logic signed [31:0]             tok_v;
	logic [4:0]                     idx5;
	logic [IDXW-1:0]                idx_n;
	logic signed [mfp_pkg::SumW-1:0] sum_n;
	logic signed [31:0]             ck_n, volt_n, curr_n, cap_n, temp_n, stat_n, time_n;

	assign idx5     = 5'(idx_q);
	assign is_digit = (char_in >= ChZero) && (char_in <= ChNine);
	assign is_space = (char_in == ChSpace) || ((char_in >= ChTab) && (char_in <= ChCr));
	assign mac      = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + 35'(char_in - ChZero);

	always_comb begin
		tail_n    = tail_q;
		in_data_n = in_data_q;
		hdr_n     = hdr_q;
		dcount_n  = dcount_q;
		take_data = 1'b0;
		if (!in_data_q) begin
			if (char_in == ChEq) begin
				in_data_n = 1'b1;
				hdr_n     = (tail_q == HdrTag);
			end else begin
				tail_n = {tail_q[7:0], char_in};
			end
		end else if (dcount_q < DCW'(MAX_DATA_CHARS)) begin
			take_data = 1'b1;
			dcount_n  = dcount_q + DCW'(1);
		end
	end

	// Per-character token state update
	always_comb begin
		ph_n  = phase_q;
		neg_n = neg_q;
		val_n = val_q;
		comma = take_data && (char_in == ChComma);
		if (take_data && !comma) begin
			case (phase_q)
				PH_EMPTY, PH_SPACE: begin
					if (is_space) begin
						ph_n = PH_SPACE;
					end else if (char_in == ChPlus || char_in == ChMinus) begin
						neg_n = (char_in == ChMinus);
						ph_n  = PH_NUM;
					end else if (is_digit) begin
						val_n = (mac > ValMax) ? ValMax[30:0] : mac[30:0];
						ph_n  = PH_NUM;
					end else begin
						ph_n = PH_STOP;
					end
				end
				PH_NUM: begin
					if (is_digit) begin
						val_n = (mac > ValMax) ? ValMax[30:0] : mac[30:0];
					end else begin
						ph_n = PH_STOP;
					end
				end
				default: ph_n = phase_q;
			endcase
		end
	end

	// Close the token on a comma or at the end of the frame
	always_comb begin
		end_now = comma || frame_last;
		commit  = end_now && (ph_n != PH_EMPTY) && (idx_q < IDXW'(MAX_TOKENS));
		tok_v   = neg_n ? -$signed({1'b0, val_n}) : $signed({1'b0, val_n});
		sum_n   = sum_q;
		ck_n    = ck_q;
		volt_n  = volt_q;
		curr_n  = curr_q;
		cap_n   = cap_q;
		temp_n  = temp_q;
		stat_n  = stat_q;
		time_n  = time_q;
		idx_n   = idx_q;
		if (commit) begin
			idx_n = idx_q + IDXW'(1);
			if (idx5 >= TokSumLo) begin
				sum_n = sum_q + {{(mfp_pkg::SumW - 32){tok_v[31]}}, tok_v};
			end
			case (idx5)
				TokCk:     ck_n   = tok_v;
				TokVolt:   volt_n = tok_v;
				TokCurr:   curr_n = tok_v;
				TokCap:    cap_n  = tok_v;
				TokTemp:   temp_n = tok_v;
				TokStatus: stat_n = tok_v;
				TokTime:   time_n = tok_v;
				default:   ck_n   = ck_q;
			endcase
		end
	end

	always_comb begin
		rec_push     = accept && frame_last;
		rec.hdr_ok   = hdr_n;
		rec.temp_ok  = 5'(idx_n) > TokTemp;
		rec.sum      = sum_n;
		rec.ck       = ck_n;
		rec.volt     = volt_n;
		rec.curr     = curr_n;
		rec.cap      = cap_n;
		rec.temp_raw = temp_n;
		rec.stat     = stat_n[7:0];
		rec.clk_time = time_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q    <= '0;
			in_data_q <= 1'b0;
			hdr_q     <= 1'b0;
			dcount_q  <= '0;
			idx_q     <= '0;
			phase_q   <= PH_EMPTY;
			neg_q     <= 1'b0;
			val_q     <= '0;
			sum_q     <= '0;
			ck_q      <= '0;
			volt_q    <= '0;
			curr_q    <= '0;
			cap_q     <= '0;
			temp_q    <= '0;
			stat_q    <= '0;
			time_q    <= '0;
		end else if (accept) begin
			if (frame_last) begin
				// Frame done: start the next one from a clean state
				tail_q    <= '0;
				in_data_q <= 1'b0;
				hdr_q     <= 1'b0;
				dcount_q  <= '0;
				idx_q     <= '0;
				phase_q   <= PH_EMPTY;
				neg_q     <= 1'b0;
				val_q     <= '0;
				sum_q     <= '0;
				ck_q      <= '0;
				volt_q    <= '0;
				curr_q    <= '0;
				cap_q     <= '0;
				temp_q    <= '0;
				stat_q    <= '0;
				time_q    <= '0;
			end else begin
				tail_q    <= tail_n;
				in_data_q <= in_data_n;
				hdr_q     <= hdr_n;
				dcount_q  <= dcount_n;
				idx_q     <= idx_n;
				phase_q   <= end_now ? PH_EMPTY : ph_n;
				neg_q     <= end_now ? 1'b0 : neg_n;
				val_q     <= end_now ? '0 : val_n;
				sum_q     <= sum_n;
				ck_q      <= ck_n;
				volt_q    <= volt_n;
				curr_q    <= curr_n;
				cap_q     <= cap_n;
				temp_q    <= temp_n;
				stat_q    <= stat_n;
				time_q    <= time_n;
			end
		end
	end

endmodule

// ===== rtl/mfp_queue.sv =====
// Short record queue between the parser and the checker.
// Depends on mfp_pkg for the record type.
module mfp_queue #(
	parameter int DEPTH = mfp_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mfp_pkg::rec_t din,
	output logic          full,
	input  logic          pop,
	output mfp_pkg::rec_t dout,
	output logic          empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mfp_pkg::rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/mfp_back.sv =====
// Checker: checksum modulo 255, status check, temperature offset, result register.
// Depends on mfp_pkg for the record type and check constants.
module mfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mfp_pkg::rec_t      rec,
	input  logic               rec_valid,
	output logic               rec_take,
	input  logic               pop,
	output logic               empty,
	output logic               frame_ok,
	output logic [1:0]         error_code,
	output logic signed [31:0] voltage_centi,
	output logic signed [31:0] current_centi,
	output logic signed [31:0] capacity_milli,
	output logic signed [31:0] temperature_deg,
	output logic [7:0]         output_status,
	output logic               output_active,
	output logic signed [31:0] time_hhmmss,
	output logic signed [31:0] checksum_received
);

	localparam logic signed [32:0] TempMin = -33'sd2147483647;

	logic               valid_s1, valid_s2;
	logic               ld2, s1_free;

	// Stage 1 registers
	logic               hdr_s1, sneg_s1;
	logic [10:0]        bsum_s1;
	logic signed [31:0] ck_s1, volt_s1, curr_s1, cap_s1, temp_s1, time_s1;
	logic [7:0]         stat_s1;

	logic [39:0]        mag;
	logic signed [32:0] tdiff;
	logic [8:0]         fold;
	logic [7:0]         rem;
	logic signed [9:0]  modv;
	logic signed [31:0] ck_exp;
	logic               ck_good, stat_good;
	mfp_pkg::err_t      err;

	assign ld2      = valid_s1 && (!valid_s2 || pop);
	assign s1_free  = !valid_s1 || ld2;
	assign rec_take = s1_free && rec_valid;
	assign empty    = !valid_s2;

	// |sum| mod 255 folds as a sum of bytes since 256 is 1 mod 255
	always_comb begin
		mag   = rec.sum[mfp_pkg::SumW-1] ? 40'(-rec.sum) : 40'(rec.sum);
		tdiff = {rec.temp_raw[31], rec.temp_raw} - 33'(mfp_pkg::TempOffset);
		if (tdiff < TempMin) begin
			tdiff = TempMin;
		end
	end

	always_comb begin
		fold      = {1'b0, bsum_s1[7:0]} + {6'b0, bsum_s1[10:8]};
		rem       = (fold >= 9'(mfp_pkg::ChecksumMod)) ? 8'(fold - 9'(mfp_pkg::ChecksumMod))
		                                               : fold[7:0];
		modv      = sneg_s1 ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
		ck_exp    = 32'(modv) + 32'sd1;
		ck_good   = (ck_exp == ck_s1);
		stat_good = (stat_s1 <= mfp_pkg::StatusMaxCode) || (stat_s1 == mfp_pkg::StatusAltCode);
		if (!hdr_s1) begin
			err = mfp_pkg::ERR_HEADER;
		end else if (!ck_good) begin
			err = mfp_pkg::ERR_CHECKSUM;
		end else if (!stat_good) begin
			err = mfp_pkg::ERR_STATUS;
		end else begin
			err = mfp_pkg::ERR_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			hdr_s1  <= rec.hdr_ok;
			sneg_s1 <= rec.sum[mfp_pkg::SumW-1];
			bsum_s1 <= 11'(mag[7:0]) + 11'(mag[15:8]) + 11'(mag[23:16])
			         + 11'(mag[31:24]) + 11'(mag[39:32]);
			ck_s1   <= rec.ck;
			volt_s1 <= rec.volt;
			curr_s1 <= rec.curr;
			cap_s1  <= rec.cap;
			temp_s1 <= rec.temp_ok ? tdiff[31:0] : 32'sd0;
			stat_s1 <= rec.stat;
			time_s1 <= rec.clk_time;
		end
		if (ld2) begin
			// Missing header blanks every data field
			frame_ok          <= (err == mfp_pkg::ERR_OK);
			error_code        <= err;
			voltage_centi     <= hdr_s1 ? volt_s1 : 32'sd0;
			current_centi     <= hdr_s1 ? curr_s1 : 32'sd0;
			capacity_milli    <= hdr_s1 ? cap_s1 : 32'sd0;
			temperature_deg   <= hdr_s1 ? temp_s1 : 32'sd0;
			output_status     <= hdr_s1 ? stat_s1 : 8'd0;
			output_active     <= (err == mfp_pkg::ERR_OK) && (stat_s1 == 8'd0);
			time_hhmmss       <= hdr_s1 ? time_s1 : 32'sd0;
			checksum_received <= hdr_s1 ? ck_s1 : 32'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rec_take) begin
				valid_s1 <= 1'b1;
			end else if (ld2) begin
				valid_s1 <= 1'b0;
			end
			if (ld2) begin
				valid_s2 <= 1'b1;
			end else if (pop) begin
				valid_s2 <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/measurement_frame_parser.sv =====
// Top level of the measurement frame parser: parser, record queue and checker.
// Depends on mfp_pkg, mfp_front, mfp_queue and mfp_back.
//
// Channel  | Handshake        | Payload
// ---------+------------------+--------------------------------------------------
// input    | push / full      | char_in, frame_last
// result   | empty / pop      | frame_ok, error_code, voltage_centi, current_centi,
//          |                  | capacity_milli, temperature_deg, output_status,
//          |                  | output_active, time_hhmmss, checksum_received
//
// One character is taken per cycle while full is low. The edge that takes a frame's
// last character writes its record into the queue; the record then moves on into
// the checksum byte fold and then into the result register, each when that stage is free.
// Reset clears parser state, queue pointers and stage valid bits.
// The queue holds QUEUE_DEPTH finished frames; full rises only when it is
// filled and the result side is stalled, and then every character waits.
module measurement_frame_parser #(
	parameter int MAX_DATA_CHARS = mfp_pkg::MaxDataChars,
	parameter int MAX_TOKENS     = mfp_pkg::MaxTokens,
	parameter int QUEUE_DEPTH    = mfp_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_in,
	input  logic               frame_last,
	output logic               empty,
	input  logic               pop,
	output logic               frame_ok,
	output logic [1:0]         error_code,
	output logic signed [31:0] voltage_centi,
	output logic signed [31:0] current_centi,
	output logic signed [31:0] capacity_milli,
	output logic signed [31:0] temperature_deg,
	output logic [7:0]         output_status,
	output logic               output_active,
	output logic signed [31:0] time_hhmmss,
	output logic signed [31:0] checksum_received
);

	logic          accept;
	logic          rec_push, rec_take, q_empty;
	mfp_pkg::rec_t rec_in, rec_out;

	// Transfer a character only while the queue can take a finished frame
	assign accept = push && !full;

	mfp_front #(
		.MAX_DATA_CHARS(MAX_DATA_CHARS),
		.MAX_TOKENS    (MAX_TOKENS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_in   (char_in),
		.frame_last(frame_last),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	// Decouple parsing from checking so either side can stall alone
	mfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.din   (rec_in),
		.full  (full),
		.pop   (rec_take),
		.dout  (rec_out),
		.empty (q_empty)
	);

	mfp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rec              (rec_out),
		.rec_valid        (!q_empty),
		.rec_take         (rec_take),
		.pop              (pop),
		.empty            (empty),
		.frame_ok         (frame_ok),
		.error_code       (error_code),
		.voltage_centi    (voltage_centi),
		.current_centi    (current_centi),
		.capacity_milli   (capacity_milli),
		.temperature_deg  (temperature_deg),
		.output_status    (output_status),
		.output_active    (output_active),
		.time_hhmmss      (time_hhmmss),
		.checksum_received(checksum_received)
	);

endmodule
